// ===== hdl/zdpsf_pkg.sv =====
// ----------------------------------------------------------------------------
// zdpsf_pkg - shared types and codes for the zero-delimited packet slot framer
// Holds the command and result word layouts, op codes, status codes, the delimiter and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package zdpsf_pkg;

    // Operation codes of a command word
    localparam logic [1:0] OP_BYTE    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    // Status codes of a result word
    localparam logic [3:0] ST_STORED      = 4'd0;
    localparam logic [3:0] ST_DELIM_IDLE  = 4'd1;
    localparam logic [3:0] ST_PUBLISHED   = 4'd2;
    localparam logic [3:0] ST_DELIM_DROP  = 4'd3;
    localparam logic [3:0] ST_FULL_DROP   = 4'd4;
    localparam logic [3:0] ST_TOO_LONG    = 4'd5;
    localparam logic [3:0] ST_DISCARDED   = 4'd6;
    localparam logic [3:0] ST_RELEASED    = 4'd7;
    localparam logic [3:0] ST_REL_EMPTY   = 4'd8;
    localparam logic [3:0] ST_READ_OK     = 4'd9;
    localparam logic [3:0] ST_READ_RANGE  = 4'd10;

    // Packet delimiter byte
    localparam logic [7:0] DELIM = 8'h00;

    // Register map
    localparam logic       REG_MAX_LEN     = 1'b0;
    localparam logic [13:0] MAX_LEN_RESET  = 14'd8192;

    // Width used for length limit compares (covers slot sizes up to 131071)
    localparam int LIM_W = 17;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic [1:0]  read_slot;
        logic [12:0] read_pos;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [1:0]  slot_number;
        logic [13:0] packet_length;
        logic [7:0]  read_data;
        logic [1:0]  ready_slots;
        logic [31:0] overrun_drops;
        logic [31:0] overflow_drops;
    } rsp_t;

endpackage

`default_nettype wire

// ===== hdl/zdpsf_ram.sv =====
// ----------------------------------------------------------------------------
// zdpsf_ram - generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module zdpsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/zero_delimited_packet_slot_framer_top.sv =====
// ----------------------------------------------------------------------------
// zero_delimited_packet_slot_framer_top - splits a byte stream on 0x00 into
// a ring of packet slots held in one byte RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive item and pulse start; a word is taken at any edge
//   with start high and busy low. busy stays low, so one command word can be
//   issued every cycle. Op 0 feeds a stream byte, op 1 releases the oldest
//   published slot, op 2 reads one byte of a published slot, op 3 is ignored.
//   Result channel: every command except op 3 yields one result word, shown
//   on result for exactly one cycle with done high, in the cycle right after
//   the command edge. Read data comes straight from the registered
//   read port of the slot RAM; the slot RAM write and read ports are separate
//   and a read only ever targets a published slot, which is never written.
//   The receiver cannot stall; results are in command order.
//   Configuration: APB write to byte address 0 sets max_packet_len (14 bits);
//   the active limit is the smaller of it and SLOT_BYTES.
//   Reset: asynchronous, active low; clears slot flags, lengths, indices,
//   discard mode and both drop counters, and loads max_packet_len = 8192.
//   The slot RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_delimited_packet_slot_framer_top
    import zdpsf_pkg::*;
#(
    parameter int SLOT_COUNT = 3,
    parameter int SLOT_BYTES = 8192
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire cmd_t        item,
    // result channel
    output logic             done,
    output rsp_t             result,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W  = $clog2(SLOT_BYTES);
    localparam int WPOS_W = $clog2(SLOT_BYTES + 1);
    localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
    localparam int DEPTH  = SLOT_COUNT * SLOT_BYTES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_COUNT - 1);

    // ---------------------------------------------------------------------
    // State registers
    // ---------------------------------------------------------------------
    logic [13:0]       max_len_reg;
    logic [SLOT_W-1:0] prod_reg, prod_next;
    logic [SLOT_W-1:0] cons_reg, cons_next;
    logic [WPOS_W-1:0] wpos_reg, wpos_next;
    logic              discard_reg, discard_next;
    logic [31:0]       overrun_reg, overrun_next;
    logic [31:0]       overflow_reg, overflow_next;
    logic [CNT_W-1:0]  ready_reg, ready_next;
    logic [SLOT_COUNT-1:0] full_reg, full_next;
    logic [WPOS_W-1:0] len_reg [SLOT_COUNT];
    logic [WPOS_W-1:0] len_next [SLOT_COUNT];

    // result staging
    logic              done_reg;
    logic              rd_sel_reg;
    rsp_t              res_reg, res_next;
    logic              emit;

    // RAM ports
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    // decode helpers
    logic              accept;
    logic [LIM_W-1:0]  limit;
    logic [3:0]        rs_ext;
    logic [SLOT_W-1:0] rs_idx;
    logic              rd_hit;
    logic [LIM_W-1:0]  rp_ext;
    logic              cfg_wr;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // ---------------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_MAX_LEN))
        begin
            max_len_reg <= pwdata[13:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_MAX_LEN)
        begin
            prdata = {18'd0, max_len_reg};
        end
    end

    // ---------------------------------------------------------------------
    // Effective limit and read decode
    // ---------------------------------------------------------------------
    always_comb
    begin
        limit = LIM_W'(max_len_reg);
        if (limit > LIM_W'(SLOT_BYTES))
        begin
            limit = LIM_W'(SLOT_BYTES);
        end
    end

    assign rs_ext = {2'b00, item.read_slot};
    assign rs_idx = rs_ext[SLOT_W-1:0];
    assign rp_ext = LIM_W'(item.read_pos);
    assign rd_hit = (rs_ext < 4'(SLOT_COUNT)) && full_reg[rs_idx]
                    && (rp_ext < LIM_W'(len_reg[rs_idx]));

    // Slot RAM addresses: slot * SLOT_BYTES + position
    assign ram_waddr = ADDR_W'(prod_reg) * ADDR_W'(SLOT_BYTES)
                       + ADDR_W'(wpos_reg[POS_W-1:0]);
    assign ram_raddr = ADDR_W'(rs_idx) * ADDR_W'(SLOT_BYTES)
                       + ADDR_W'(rp_ext[POS_W-1:0]);

    // ---------------------------------------------------------------------
    // Command decode and next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        prod_next     = prod_reg;
        cons_next     = cons_reg;
        wpos_next     = wpos_reg;
        discard_next  = discard_reg;
        overrun_next  = overrun_reg;
        overflow_next = overflow_reg;
        ready_next    = ready_reg;
        full_next     = full_reg;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            len_next[i] = len_reg[i];
        end
        ram_we = 1'b0;
        ram_re = 1'b0;
        emit   = 1'b0;
        res_next = '0;

        if (accept)
        begin
            case (item.op)
                OP_BYTE:
                begin
                    emit = 1'b1;
                    if (item.data_byte == DELIM)
                    begin
                        // close the packet: publish, drop or idle
                        res_next.status = ST_DELIM_IDLE;
                        if (!discard_reg && (wpos_reg != '0))
                        begin
                            if (full_reg[prod_reg])
                            begin
                                overrun_next    = overrun_reg + 32'd1;
                                res_next.status = ST_DELIM_DROP;
                            end
                            else
                            begin
                                len_next[prod_reg]     = wpos_reg;
                                full_next[prod_reg]    = 1'b1;
                                ready_next             = ready_reg + CNT_W'(1);
                                res_next.status        = ST_PUBLISHED;
                                res_next.slot_number   = 2'(prod_reg);
                                res_next.packet_length = 14'(wpos_reg);
                                prod_next = (prod_reg == LAST_SLOT) ? '0
                                            : prod_reg + SLOT_W'(1);
                            end
                        end
                        wpos_next    = '0;
                        discard_next = 1'b0;
                    end
                    else if (discard_reg)
                    begin
                        res_next.status = ST_DISCARDED;
                    end
                    else if (full_reg[prod_reg])
                    begin
                        // producer slot still held: drop until next delimiter
                        discard_next    = 1'b1;
                        wpos_next       = '0;
                        overrun_next    = overrun_reg + 32'd1;
                        res_next.status = ST_FULL_DROP;
                    end
                    else if (LIM_W'(wpos_reg) < limit)
                    begin
                        // store the byte and advance the write position
                        ram_we          = 1'b1;
                        wpos_next       = wpos_reg + WPOS_W'(1);
                        res_next.status = ST_STORED;
                    end
                    else
                    begin
                        discard_next    = 1'b1;
                        wpos_next       = '0;
                        overflow_next   = overflow_reg + 32'd1;
                        res_next.status = ST_TOO_LONG;
                    end
                end
                OP_RELEASE:
                begin
                    emit = 1'b1;
                    if (full_reg[cons_reg])
                    begin
                        res_next.status        = ST_RELEASED;
                        res_next.slot_number   = 2'(cons_reg);
                        res_next.packet_length = 14'(len_reg[cons_reg]);
                        len_next[cons_reg]     = '0;
                        full_next[cons_reg]    = 1'b0;
                        ready_next             = ready_reg - CNT_W'(1);
                        cons_next = (cons_reg == LAST_SLOT) ? '0
                                    : cons_reg + SLOT_W'(1);
                    end
                    else
                    begin
                        res_next.status = ST_REL_EMPTY;
                    end
                end
                OP_READ:
                begin
                    emit = 1'b1;
                    if (rd_hit)
                    begin
                        ram_re               = 1'b1;
                        res_next.status      = ST_READ_OK;
                        res_next.slot_number = item.read_slot;
                    end
                    else
                    begin
                        res_next.status = ST_READ_RANGE;
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end

        res_next.ready_slots    = 2'(ready_next);
        res_next.overrun_drops  = overrun_next;
        res_next.overflow_drops = overflow_next;
    end

    // ---------------------------------------------------------------------
    // Control state update
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg     <= '0;
            cons_reg     <= '0;
            wpos_reg     <= '0;
            discard_reg  <= 1'b0;
            overrun_reg  <= 32'd0;
            overflow_reg <= 32'd0;
            ready_reg    <= '0;
            full_reg     <= '0;
            done_reg     <= 1'b0;
            rd_sel_reg   <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                len_reg[i] <= '0;
            end
        end
        else
        begin
            prod_reg     <= prod_next;
            cons_reg     <= cons_next;
            wpos_reg     <= wpos_next;
            discard_reg  <= discard_next;
            overrun_reg  <= overrun_next;
            overflow_reg <= overflow_next;
            ready_reg    <= ready_next;
            full_reg     <= full_next;
            done_reg     <= emit;
            rd_sel_reg   <= ram_re;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                len_reg[i] <= len_next[i];
            end
        end
    end

    // Capture the result word of each emitting command; it holds until the next one
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    // ---------------------------------------------------------------------
    // Slot byte store
    // ---------------------------------------------------------------------
    zdpsf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (item.data_byte),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Drive the result word; read data comes from the RAM read register
    always_comb
    begin
        result           = res_reg;
        result.read_data = rd_sel_reg ? ram_rdata : 8'd0;
    end

    assign done = done_reg;

endmodule

`default_nettype wire
